// File: rtl/core/flnta_pkg.sv
// Shared types, constants and helpers of the number to ASCII unit.
package flnta_pkg;

  // Default digit limit and fixed field widths
  localparam int MAX_DIGITS_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int COUNT_W        = 6;
  localparam int LINE_W         = 3;
  localparam int SCOL_W         = 5;
  localparam int COL_W          = 6;
  localparam int CHAR_W         = 7;
  localparam int DEC_DIGITS     = 10;
  localparam int BCD_W          = DEC_DIGITS * 4;
  localparam int BITCNT_W       = $clog2(VALUE_W);

  // Character codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_A     = 7'h41;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [3:0]        RADIX_DEC = 4'd10;

  typedef enum logic [1:0] {
    REQ_UDEC = 2'd0,
    REQ_SDEC = 2'd1,
    REQ_HEX  = 2'd2,
    REQ_BIN  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } flnta_state_t;

  // Request to the decimal converter
  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] value;
  } conv_req_t;

  // Status from the decimal converter
  typedef struct packed {
    logic             done;
    logic [BCD_W-1:0] bcd;
  } conv_stat_t;

  // Map a digit code to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [3:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < RADIX_DEC) begin
      ch = CH_ZERO + CHAR_W'(d);
    end else begin
      ch = CH_A + CHAR_W'(d - RADIX_DEC);
    end
    return ch;
  endfunction

endpackage

// File: rtl/core/flnta_if.sv
// Request and character channel interfaces of the number to ASCII unit.
interface flnta_in_if;
  import flnta_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [VALUE_W-1:0] value;
  logic [COUNT_W-1:0] digit_count;
  logic [LINE_W-1:0]  text_line;
  logic [SCOL_W-1:0]  start_column;

  modport source (output valid, req_type, value, digit_count, text_line, start_column,
                  input ready);
  modport sink (input valid, req_type, value, digit_count, text_line, start_column,
                output ready);
  modport monitor (input valid, ready, req_type, value, digit_count, text_line,
                   start_column);
endinterface

interface flnta_out_if;
  import flnta_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ascii_char;
  logic [LINE_W-1:0] char_line;
  logic [COL_W-1:0]  char_column;
  logic              last_char;

  modport source (output valid, ascii_char, char_line, char_column, last_char,
                  input ready);
  modport sink (input valid, ascii_char, char_line, char_column, last_char,
                output ready);
  modport monitor (input valid, ready, ascii_char, char_line, char_column, last_char);
endinterface

// File: rtl/core/flnta_bcd_conv.sv
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
module flnta_bcd_conv (
  input  logic                  clk,
  input  logic                  rst_n,
  input  flnta_pkg::conv_req_t  conv_req,
  output flnta_pkg::conv_stat_t conv_stat
);
  import flnta_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [BITCNT_W-1:0] cnt_r, cnt_nxt;
  logic [VALUE_W-1:0]  shift_r, shift_nxt;
  logic [BCD_W-1:0]    bcd_r, bcd_nxt;
  logic [BCD_W-1:0]    bcd_adj;

  // Add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int j = 0; j < DEC_DIGITS; j++) begin
      if (bcd_r[j*4 +: 4] >= 4'd5) begin
        bcd_adj[j*4 +: 4] = bcd_r[j*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[j*4 +: 4] = bcd_r[j*4 +: 4];
      end
    end
  end

  // Load on start, then shift one magnitude bit in per cycle
  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    bcd_nxt   = bcd_r;
    if (conv_req.start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      shift_nxt = conv_req.value;
      bcd_nxt   = '0;
    end else if (busy_r) begin
      bcd_nxt   = {bcd_adj[BCD_W-2:0], shift_r[VALUE_W-1]};
      shift_nxt = {shift_r[VALUE_W-2:0], 1'b0};
      cnt_nxt   = cnt_r + 1'b1;
      if (cnt_r == BITCNT_W'(VALUE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    bcd_r   <= bcd_nxt;
  end

  assign conv_stat.done = done_r;
  assign conv_stat.bcd  = bcd_r;

endmodule

// File: rtl/core/fixed_length_number_to_ascii_unit.sv
// Top level of the fixed-width number to ASCII character unit.
//
// in_chan takes one request: mode (unsigned decimal, signed decimal, hex,
// binary), a 32-bit value, a digit count, a text line and a start column.
// out_chan returns one character per cycle, most significant digit first,
// each with its line and column; last_char marks the end of the run.
// Signed mode sends '+' or '-' ahead of the digits. Only the lowest digits
// are kept when the count is short, and positions beyond the number's width
// give '0'. Counts above MAX_DIGITS are cut to MAX_DIGITS.
// A hex or binary request goes from idle straight to emitting characters; a
// decimal request first waits in the convert state while the bit-serial BCD
// converter shifts in every value bit, and emits once the converter is done.
// Characters then follow one per cycle while out_chan.ready is high.
// in_chan.ready is high only between requests; the last character may still
// wait in the output register while the next request is taken.
// A stall on out_chan holds the character and pauses the sequencer.
// Reset empties the output register and returns the sequencer to idle.
module fixed_length_number_to_ascii_unit #(
  parameter int MAX_DIGITS = flnta_pkg::MAX_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  flnta_in_if.sink    in_chan,
  flnta_out_if.source out_chan
);
  import flnta_pkg::*;

  localparam int CW = $clog2(MAX_DIGITS + 1);

  flnta_state_t        state_r, state_nxt;
  req_type_t           mode_r, mode_nxt;
  logic [VALUE_W-1:0]  mag_r, mag_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [LINE_W-1:0]   line_r, line_nxt;
  logic                sign_pend_r, sign_pend_nxt;
  logic                neg_r, neg_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic [LINE_W-1:0]   out_line_r, out_line_nxt;
  logic [COL_W-1:0]    out_col_r, out_col_nxt;
  logic                out_last_r, out_last_nxt;

  conv_req_t           conv_req;
  conv_stat_t          conv_stat;

  req_type_t           in_mode;
  logic                in_neg;
  logic [VALUE_W-1:0]  in_mag;
  logic [CW-1:0]       in_count;
  logic                can_load;
  logic [CW-1:0]       pos;
  logic [5:0]          pos_x;
  logic [63:0]         bcd_pad;
  logic [3:0]          digit;
  logic                digit_last;

  flnta_bcd_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .conv_req  (conv_req),
    .conv_stat (conv_stat)
  );

  // Decode the incoming request
  assign in_mode  = req_type_t'(in_chan.req_type);
  assign in_neg   = (in_mode == REQ_SDEC) && in_chan.value[VALUE_W-1];
  assign in_mag   = in_neg ? (~in_chan.value + 1'b1) : in_chan.value;
  assign in_count = (in_chan.digit_count > COUNT_W'(MAX_DIGITS)) ? CW'(MAX_DIGITS)
                                                                  : CW'(in_chan.digit_count);

  // Pick the digit at the current position, most significant first
  assign pos        = count_r - 1'b1 - idx_r;
  assign pos_x      = 6'(pos);
  assign bcd_pad    = {{(64 - BCD_W){1'b0}}, conv_stat.bcd};
  assign digit_last = (idx_r == count_r - 1'b1);

  always_comb begin
    case (mode_r)
      REQ_HEX:  digit = (pos_x < 6'd8) ? mag_r[pos_x[2:0]*4 +: 4] : 4'd0;
      REQ_BIN:  digit = pos_x[5] ? 4'd0 : {3'b000, mag_r[pos_x[4:0]]};
      default:  digit = (pos_x < 6'd16) ? bcd_pad[pos_x[3:0]*4 +: 4] : 4'd0;
    endcase
  end

  assign can_load = !out_valid_r || out_chan.ready;

  // Sequencer: take a request, convert, then emit characters
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    mag_nxt       = mag_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    col_nxt       = col_r;
    line_nxt      = line_r;
    sign_pend_nxt = sign_pend_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_char_nxt  = out_char_r;
    out_line_nxt  = out_line_r;
    out_col_nxt   = out_col_r;
    out_last_nxt  = out_last_r;
    conv_req.start = 1'b0;
    conv_req.value = in_mag;
    in_chan.ready  = (state_r == ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          mode_nxt      = in_mode;
          mag_nxt       = in_mag;
          count_nxt     = in_count;
          idx_nxt       = '0;
          col_nxt       = COL_W'(in_chan.start_column);
          line_nxt      = in_chan.text_line;
          sign_pend_nxt = (in_mode == REQ_SDEC);
          neg_nxt       = in_neg;
          if (in_mode == REQ_UDEC || in_mode == REQ_SDEC) begin
            conv_req.start = 1'b1;
            state_nxt      = ST_CONV;
          end else if (in_count != '0) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_CONV: begin
        if (conv_stat.done) begin
          state_nxt = (sign_pend_r || count_r != '0) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_line_nxt  = line_r;
          out_col_nxt   = col_r;
          col_nxt       = col_r + 1'b1;
          if (sign_pend_r) begin
            out_char_nxt  = neg_r ? CH_MINUS : CH_PLUS;
            out_last_nxt  = (count_r == '0);
            sign_pend_nxt = 1'b0;
            if (count_r == '0) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            out_char_nxt = digit_to_ascii(digit);
            out_last_nxt = digit_last;
            idx_nxt      = idx_r + 1'b1;
            if (digit_last) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sign_pend_r <= 1'b0;
      idx_r       <= '0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sign_pend_r <= sign_pend_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
    end
  end

  // Hold request and character payload
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    mag_r      <= mag_nxt;
    col_r      <= col_nxt;
    line_r     <= line_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_line_r <= out_line_nxt;
    out_col_r  <= out_col_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.ascii_char  = out_char_r;
  assign out_chan.char_line   = out_line_r;
  assign out_chan.char_column = out_col_r;
  assign out_chan.last_char   = out_last_r;

endmodule

// File: rtl/core/flnta_checker.sv
// Port-level checks of the number to ASCII unit, bound to the top level.
module flnta_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [flnta_pkg::COUNT_W-1:0] in_digit_count,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [flnta_pkg::CHAR_W-1:0]  out_ascii_char,
  input logic [flnta_pkg::COL_W-1:0]   out_char_column,
  input logic                          out_last_char
);
  import flnta_pkg::*;

  // Hold a stalled character
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ascii_char)
      && $stable(out_char_column) && $stable(out_last_char))
    else $error("stalled character changed");

  // Drop ready after a request that produces digits
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_digit_count != '0 |=> !in_ready)
    else $error("request taken while busy");

  // Emit only digits, hex letters and signs
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ascii_char >= CH_ZERO && out_ascii_char <= 7'h39)
      || (out_ascii_char >= CH_A && out_ascii_char <= 7'h46)
      || out_ascii_char == CH_PLUS || out_ascii_char == CH_MINUS)
    else $error("illegal character");

  // Advance the column by one within a run, with no gap
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_char |=>
      out_valid && out_char_column == $past(out_char_column) + 6'd1)
    else $error("run broken or column skipped");

endmodule

bind fixed_length_number_to_ascii_unit flnta_checker u_flnta_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .in_digit_count  (in_chan.digit_count),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_ascii_char  (out_chan.ascii_char),
  .out_char_column (out_chan.char_column),
  .out_last_char   (out_chan.last_char)
);
